@@ sv/per_cpu_page_free_list_allocator_core_defines.svh @@
// Assertion helpers shared by the allocator modules.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define PCPFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcpfa: same-cycle check failed");

// next-cycle implication
`define PCPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcpfa: next-cycle check failed");

`endif

@@ sv/pcpfa_pkg.sv @@
package pcpfa_pkg;

   localparam int ADDR_W    = 56;
   localparam int CPU_W     = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 56;

   localparam int DEF_CPUS       = 8;
   localparam int DEF_PAGES      = 32768;
   localparam int DEF_PAGE_BYTES = 4096;
   // link word: valid bit above the page index
   localparam int DEF_LINK_W     = $clog2(DEF_PAGES) + 1;

   localparam logic [ADDR_W-1:0] LOW_LIMIT_RST  = 56'h0000_0080_000000;
   localparam logic [ADDR_W-1:0] HIGH_LIMIT_RST = 56'h0000_0088_000000;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FREE  = 2'd1,
      STATUS_BAD_ADDR = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LIMIT  = 1'b0,
      CSR_HIGH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FREE,
      ST_SELECT,
      ST_LINK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic idle;
      logic capture;
      logic check;
      logic push;
      logic select;
      logic pop;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic none_free;
      logic out_free;
   } dp_status_type;

endpackage

@@ sv/pcpfa_req_if.sv @@
interface pcpfa_req_if import pcpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   opcode_type        opcode;
   logic [CPU_W-1:0]  cpu_id;
   logic [ADDR_W-1:0] page_address;

   modport source (output valid, opcode, cpu_id, page_address, input ready);
   modport sink   (input valid, opcode, cpu_id, page_address, output ready);
endinterface

@@ sv/pcpfa_rsp_if.sv @@
interface pcpfa_rsp_if import pcpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] alloc_address;
   status_type        status;

   modport source (output valid, alloc_address, status, input ready);
   modport sink   (input valid, alloc_address, status, output ready);
endinterface

@@ sv/pcpfa_ram.sv @@
module pcpfa_ram import pcpfa_pkg::*; #(
   parameter int WIDTH = DEF_LINK_W,
   parameter int DEPTH = DEF_PAGES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/pcpfa_ctrl.sv @@
`include "per_cpu_page_free_list_allocator_core_defines.svh"

module pcpfa_ctrl import pcpfa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  opcode_type    req_opcode,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_opcode == OP_FREE) ? ST_CHECK : ST_SELECT;
            end
         end
         ST_CHECK:  state_in = ST_FREE;
         ST_FREE:   state_in = ST_DONE;
         ST_SELECT: state_in = stat.none_free ? ST_DONE : ST_LINK;
         ST_LINK:   state_in = ST_DONE;
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // no word is taken while reset is held
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle    = ~reset;
            cmd.capture = req_valid & ~reset;
         end
         ST_CHECK:  cmd.check  = 1'b1;
         ST_FREE:   cmd.push   = 1'b1;
         ST_SELECT: cmd.select = 1'b1;
         ST_LINK:   cmd.pop    = 1'b1;
         ST_DONE:   cmd.load   = stat.out_free;
         default:   cmd        = '0;
      endcase
   end

   `PCPFA_ASSERT_NEXT(a_empty_skips_link, clock, reset, (state_ff == ST_SELECT) && stat.none_free, state_ff == ST_DONE)
   `PCPFA_ASSERT_NEXT(a_capture_leaves_idle, clock, reset, cmd.capture, state_ff != ST_IDLE)
endmodule

@@ sv/pcpfa_dp.sv @@
`include "per_cpu_page_free_list_allocator_core_defines.svh"

module pcpfa_dp import pcpfa_pkg::*; #(
   parameter int CPUS       = DEF_CPUS,
   parameter int PAGES      = DEF_PAGES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  logic [CPU_W-1:0]     req_cpu_id,
   input  logic [ADDR_W-1:0]    req_page_address,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [ADDR_W-1:0]    rsp_alloc_address,
   output status_type           rsp_status,
   input  dp_cmd_type           cmd,
   output dp_status_type        stat
);
   localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
   localparam int PW = $clog2(PAGES);
   localparam int SH = $clog2(PAGE_BYTES);
   localparam int OW = ADDR_W + 1;    // base may round up past 56 bits
   localparam int LW = PW + 1;
   localparam logic [OW-SH-1:0] PAGES_V = (OW-SH)'(PAGES);

   // limits and rounded window base
   logic [ADDR_W-1:0] low_ff, high_ff;
   logic [OW-1:0]     base_ff, base_in, base_sum;

   // item under work
   logic [CW-1:0]     cpu_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              lim_bad_ff, lim_bad_in;
   logic [OW:0]       off_ff, off_in;      // top bit is the borrow
   logic              bad;
   logic [PW-1:0]     push_idx;

   // list heads
   logic [CPUS-1:0]   head_v_ff;
   logic [PW-1:0]     head_p_ff [CPUS];
   logic [CW-1:0]     low_sel, sel, sel_ff;
   logic [PW-1:0]     page_ff;
   logic              none;

   // link store
   logic              mem_we;
   logic [LW-1:0]     mem_wdata, mem_rdata;

   // result
   logic [OW-1:0]     alloc_sum;
   logic [ADDR_W-1:0] res_addr_ff, rsp_addr_ff;
   status_type        res_status_ff, rsp_status_ff;
   logic              rsp_valid_ff;

   function automatic logic [CW-1:0] cpu_wrap(input logic [CPU_W-1:0] id);
      logic [CPU_W:0] v;
      v = {1'b0, id};
      for (int i = 0; i < (1 << CPU_W); i++) begin
         if (int'(v) >= CPUS) begin
            v = v - (CPU_W+1)'(CPUS);
         end
      end
      return CW'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LOW_LIMIT_RST;
         high_ff <= HIGH_LIMIT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_LIMIT:  low_ff  <= csr_write_data;
            CSR_HIGH_LIMIT: high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign base_sum = {1'b0, low_ff} + OW'(PAGE_BYTES - 1);
   assign base_in  = {base_sum[OW-1:SH], {SH{1'b0}}};

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cpu_ff  <= cpu_wrap(req_cpu_id);
         addr_ff <= req_page_address;
      end
   end

   // free checks, first half: limits and offset from the window base
   assign lim_bad_in = (|addr_ff[SH-1:0]) | (addr_ff < low_ff) | (addr_ff >= high_ff);
   assign off_in     = {2'b00, addr_ff} - {1'b0, base_ff};

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         lim_bad_ff <= lim_bad_in;
         off_ff     <= off_in;
      end
   end

   // second half: below base or past the last page
   assign bad      = lim_bad_ff | off_ff[OW] | (off_ff[OW-1:SH] >= PAGES_V);
   assign push_idx = off_ff[SH+PW-1:SH];

   // own list first, else the lowest-numbered nonempty one
   always_comb begin
      low_sel = '0;
      for (int i = CPUS - 1; i >= 0; i--) begin
         if (head_v_ff[i]) begin
            low_sel = CW'(i);
         end
      end
   end

   assign sel  = head_v_ff[cpu_ff] ? cpu_ff : low_sel;
   assign none = ~|head_v_ff;

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         sel_ff  <= sel;
         page_ff <= head_p_ff[sel];
      end
   end

   assign mem_we    = cmd.push & ~bad;
   assign mem_wdata = {head_v_ff[cpu_ff], head_p_ff[cpu_ff]};

   pcpfa_ram #(
      .WIDTH (LW),
      .DEPTH (PAGES)
   ) u_links (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (push_idx),
      .wr_data (mem_wdata),
      .rd_en   (cmd.select),
      .rd_addr (head_p_ff[sel]),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= '0;
      end else if (mem_we) begin
         head_v_ff[cpu_ff] <= 1'b1;
      end else if (cmd.pop) begin
         head_v_ff[sel_ff] <= mem_rdata[PW];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         head_p_ff[cpu_ff] <= push_idx;
      end else if (cmd.pop) begin
         head_p_ff[sel_ff] <= mem_rdata[PW-1:0];
      end
   end

   assign alloc_sum = base_ff + (OW'(page_ff) << SH);

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         res_addr_ff   <= '0;
         res_status_ff <= bad ? STATUS_BAD_ADDR : STATUS_OK;
      end else if (cmd.select && none) begin
         res_addr_ff   <= '0;
         res_status_ff <= STATUS_NO_FREE;
      end else if (cmd.pop) begin
         res_addr_ff   <= alloc_sum[ADDR_W-1:0];
         res_status_ff <= STATUS_OK;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alloc_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   assign stat.none_free = none;
   assign stat.out_free  = ~rsp_valid_ff | rsp_ready;

   `PCPFA_ASSERT_NEXT(a_push_sets_head, clock, reset, mem_we, head_v_ff[cpu_ff])
   `PCPFA_ASSERT_IMPL(a_pop_from_live, clock, reset, cmd.pop, head_v_ff[sel_ff])
   `PCPFA_ASSERT_IMPL(a_err_zero_addr, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_addr_ff == '0)
endmodule

@@ sv/per_cpu_page_free_list_allocator_core.sv @@
// Per-processor page free-list allocator.
// req_ch carries one request word: opcode (alloc or free), cpu_id and, for a
// free, the page byte address. rsp_ch returns one word per request:
// alloc_address (zero unless a page was handed out) and status
// (ok, nothing free, bad free address).
// csr_* writes low_limit (index 0) and high_limit (index 1); write only while
// no request is in flight.
// The request passes through the controller states in order: a free runs
// the limit checks (ST_CHECK), then the window check and push (ST_FREE); an
// alloc picks a list head (ST_SELECT), then waits on the registered read of
// the link store before the head moves (ST_LINK), and one that finds every
// list empty goes straight on to ST_DONE. No new request is taken until the
// result has been loaded into the output register.
// The result sits in an output register, so the block is idle again as soon as
// the result is loaded; if rsp_ch is stalled with a word still held, a
// finished request waits there until the register frees up.
// Reset empties every list and restores the limit defaults; the link store is
// not cleared, and the block takes requests as soon as reset drops.
module per_cpu_page_free_list_allocator_core import pcpfa_pkg::*; #(
   parameter int CPUS       = DEF_CPUS,
   parameter int PAGES      = DEF_PAGES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   pcpfa_req_if.sink            req_ch,
   pcpfa_rsp_if.source          rsp_ch
);
   dp_cmd_type    cmd;
   dp_status_type stat;

   pcpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcpfa_dp #(
      .CPUS       (CPUS),
      .PAGES      (PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_cpu_id        (req_ch.cpu_id),
      .req_page_address  (req_ch.page_address),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_alloc_address (rsp_ch.alloc_address),
      .rsp_status        (rsp_ch.status),
      .cmd               (cmd),
      .stat              (stat)
   );

   assign req_ch.ready = cmd.idle;
endmodule
